@@ rtl/dns_query_validator_assert.svh @@
// Assertion macros used by the DNS query validator checker.
`ifndef DNS_QUERY_VALIDATOR_ASSERT_SVH
`define DNS_QUERY_VALIDATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define DQV_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dqv assertion failed");

// Next-cycle implication, disabled while reset is high.
`define DQV_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dqv assertion failed");

`endif

@@ rtl/dqv_pkg.sv @@
// Package: types and constants for the DNS query validator.
`default_nettype none
package dqv_pkg;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_TRUNC    = 3'd1,
    ERR_RESPONSE = 3'd2,
    ERR_OPCODE   = 3'd3,
    ERR_QDCOUNT  = 3'd4,
    ERR_POINTER  = 3'd5,
    ERR_RESERVED = 3'd6,
    ERR_LONG     = 3'd7
  } err_code_t;

  localparam logic [15:0] QR_MASK     = 16'h8000;
  localparam logic [15:0] OPCODE_MASK = 16'h7800;
  localparam logic [15:0] RD_MASK     = 16'h0100;
  localparam logic [7:0]  PTR_MASK    = 8'hC0;
  localparam logic [7:0]  MAX_LABEL   = 8'd63;
  localparam logic [3:0]  HDR_LAST    = 4'd11;
  localparam logic [3:0]  POS_MAX     = 4'd15;
  localparam logic [8:0]  TYPE_CLASS_BYTES = 9'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        ok;
    logic [2:0]  error_code;
    logic [15:0] query_id;
    logic        recursion_wanted;
    logic [8:0]  name_length;
    logic [15:0] question_type;
    logic [15:0] question_class;
    logic [8:0]  question_length;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t data;
  } result_beat_t;

endpackage
`default_nettype wire

@@ rtl/dqv_parser.sv @@
// Byte-wise header and question parser: state registers and next-state logic.
`default_nettype none
module dqv_parser (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 take,
  input  wire dqv_pkg::in_item_t    item,
  input  wire logic [7:0]           name_limit,
  output dqv_pkg::result_beat_t     beat
);

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_NAME   = 3'd1,
    PH_LABEL  = 3'd2,
    PH_TAIL   = 3'd3,
    PH_DONE   = 3'd4,
    PH_REJECT = 3'd5
  } phase_t;

  phase_t              phase, phase_next;
  logic [3:0]          byte_position, byte_position_next;
  logic [5:0]          label_remaining, label_remaining_next;
  logic [8:0]          name_total, name_total_next;
  logic [15:0]         saved_id, saved_id_next;
  logic                saved_rd, saved_rd_next;
  logic [7:0]          high_byte_hold, high_byte_hold_next;
  logic [15:0]         saved_type, saved_type_next;
  logic [15:0]         saved_class, saved_class_next;
  logic [1:0]          tail_index, tail_index_next;
  dqv_pkg::err_code_t  saved_error, saved_error_next;

  logic [7:0]          b;
  logic [15:0]         word;
  logic [5:0]          label_dec;
  logic                emit_now;
  logic                emit_ok;
  dqv_pkg::err_code_t  emit_err;
  logic                clear;

  assign b         = item.data_byte;
  assign word      = {high_byte_hold, b};
  assign label_dec = label_remaining - 6'd1;

  always_comb begin
    phase_next           = phase;
    byte_position_next   = byte_position;
    label_remaining_next = label_remaining;
    name_total_next      = name_total;
    saved_id_next        = saved_id;
    saved_rd_next        = saved_rd;
    high_byte_hold_next  = high_byte_hold;
    saved_type_next      = saved_type;
    saved_class_next     = saved_class;
    tail_index_next      = tail_index;
    saved_error_next     = saved_error;
    emit_now             = item.last_byte;
    emit_ok              = 1'b0;
    emit_err             = dqv_pkg::ERR_TRUNC;

    unique case (phase)
      PH_HEADER: begin
        if (byte_position == 4'd0 || byte_position == 4'd2 || byte_position == 4'd4) begin
          high_byte_hold_next = b;
        end else if (byte_position == 4'd1) begin
          saved_id_next = word;
        end else if (byte_position == 4'd3) begin
          if (saved_error == dqv_pkg::ERR_NONE) begin
            if ((word & dqv_pkg::QR_MASK) != 16'd0) begin
              saved_error_next = dqv_pkg::ERR_RESPONSE;
            end else if ((word & dqv_pkg::OPCODE_MASK) != 16'd0) begin
              saved_error_next = dqv_pkg::ERR_OPCODE;
            end
          end
          saved_rd_next = ((word & dqv_pkg::RD_MASK) != 16'd0);
        end else if (byte_position == 4'd5) begin
          if (word != 16'd1 && saved_error == dqv_pkg::ERR_NONE) begin
            saved_error_next = dqv_pkg::ERR_QDCOUNT;
          end
        end
        if (byte_position != dqv_pkg::POS_MAX) begin
          byte_position_next = byte_position + 4'd1;
        end
        // header complete: a stored flag fault now wins over truncation
        if (byte_position >= dqv_pkg::HDR_LAST) begin
          if (saved_error != dqv_pkg::ERR_NONE) begin
            phase_next = PH_REJECT;
            emit_err   = saved_error;
          end else begin
            phase_next = PH_NAME;
          end
        end
      end
      PH_NAME: begin
        if ((b & dqv_pkg::PTR_MASK) == dqv_pkg::PTR_MASK) begin
          saved_error_next = dqv_pkg::ERR_POINTER;
          phase_next       = PH_REJECT;
          emit_err         = dqv_pkg::ERR_POINTER;
        end else if (b > dqv_pkg::MAX_LABEL) begin
          saved_error_next = dqv_pkg::ERR_RESERVED;
          phase_next       = PH_REJECT;
          emit_err         = dqv_pkg::ERR_RESERVED;
        end else if (b == 8'd0) begin
          phase_next      = PH_TAIL;
          tail_index_next = 2'd0;
        end else begin
          label_remaining_next = b[5:0];
          name_total_next      = name_total + {1'b0, b} + 9'd1;
          phase_next           = PH_LABEL;
        end
      end
      PH_LABEL: begin
        label_remaining_next = label_dec;
        if (label_dec == 6'd0) begin
          if (name_total > {1'b0, name_limit}) begin
            saved_error_next = dqv_pkg::ERR_LONG;
            phase_next       = PH_REJECT;
            emit_err         = dqv_pkg::ERR_LONG;
          end else begin
            phase_next = PH_NAME;
          end
        end
      end
      PH_TAIL: begin
        unique case (tail_index)
          2'd0, 2'd2: high_byte_hold_next = b;
          2'd1:       saved_type_next     = word;
          2'd3:       saved_class_next    = word;
          default:    high_byte_hold_next = b;
        endcase
        if (tail_index == 2'd3) begin
          phase_next = PH_DONE;
          emit_ok    = 1'b1;
        end else begin
          tail_index_next = tail_index + 2'd1;
        end
      end
      PH_DONE: begin
        emit_ok = 1'b1;
      end
      PH_REJECT: begin
        emit_err = saved_error;
      end
      default: begin
        emit_err = saved_error;
      end
    endcase
  end

  assign clear = take && emit_now;

  always_comb begin
    beat       = '0;
    beat.valid = clear;
    if (emit_ok) begin
      beat.data.ok               = 1'b1;
      beat.data.query_id         = saved_id_next;
      beat.data.recursion_wanted = saved_rd_next;
      beat.data.name_length      = name_total_next + 9'd1;
      beat.data.question_type    = saved_type_next;
      beat.data.question_class   = saved_class_next;
      beat.data.question_length  = name_total_next + 9'd1 + dqv_pkg::TYPE_CLASS_BYTES;
    end else begin
      beat.data.error_code = emit_err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      phase           <= PH_HEADER;
      byte_position   <= 4'd0;
      label_remaining <= 6'd0;
      name_total      <= 9'd0;
      saved_id        <= 16'd0;
      saved_rd        <= 1'b0;
      high_byte_hold  <= 8'd0;
      saved_type      <= 16'd0;
      saved_class     <= 16'd0;
      tail_index      <= 2'd0;
      saved_error     <= dqv_pkg::ERR_NONE;
    end else if (take) begin
      phase           <= phase_next;
      byte_position   <= byte_position_next;
      label_remaining <= label_remaining_next;
      name_total      <= name_total_next;
      saved_id        <= saved_id_next;
      saved_rd        <= saved_rd_next;
      high_byte_hold  <= high_byte_hold_next;
      saved_type      <= saved_type_next;
      saved_class     <= saved_class_next;
      tail_index      <= tail_index_next;
      saved_error     <= saved_error_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/dqv_out_reg.sv @@
// Verdict output register with valid/ready handshake.
`default_nettype none
module dqv_out_reg (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire dqv_pkg::result_beat_t beat,
  input  wire logic                  out_ready,
  output logic                       out_valid,
  output dqv_pkg::result_t           out_data,
  output logic                       room
);

  // free now, or emptied at this edge
  assign room = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (room) begin
      out_valid <= beat.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (room && beat.valid) begin
      out_data <= beat.data;
    end
  end

endmodule
`default_nettype wire

@@ rtl/dns_query_validator.sv @@
// Top level of the DNS query validator.
// Usage:
//  - in channel: one message byte per transaction (data_byte, last_byte), valid/ready.
//    last_byte marks the final byte of a DNS message.
//  - out channel: one verdict transaction per message, produced by the byte
//    carrying last_byte: ok, error_code, ID, RD bit, name and question lengths,
//    QTYPE and QCLASS. Rejected messages give ok = 0, a nonzero error_code and zeros elsewhere.
//  - cfg channel: writes name_limit (reset 255); cfg_ready is always high.
//    Write it only while no message is in flight.
//  - Throughput: one byte per cycle, back to back, across message boundaries, unless stalled.
//    Each byte is parsed by short logic feeding the parser state registers.
//  - Verdict timing: the verdict is registered and appears on out_valid in the cycle after
//    the last byte is accepted.
//  - Stall: the verdict register holds while out_ready is low. Bytes that do
//    not end a message are still not taken then either: in_ready follows the
//    verdict register being empty or being drained this cycle.
//  - Reset (rst, synchronous, active high) clears parser state, drops any
//    pending verdict and restores name_limit to 255.
`default_nettype none
module dns_query_validator (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire dqv_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output dqv_pkg::result_t       out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [7:0]        cfg_data
);

  logic [7:0]            limit_q;
  dqv_pkg::result_beat_t beat;
  logic                  take;
  logic                  room;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_q <= 8'hFF;
    end else if (cfg_valid && cfg_ready) begin
      limit_q <= cfg_data;
    end
  end

  assign in_ready = room;
  assign take     = in_valid && in_ready;

  dqv_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .item       (in_data),
    .name_limit (limit_q),
    .beat       (beat)
  );

  dqv_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .beat      (beat),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .room      (room)
  );

endmodule
`default_nettype wire

@@ rtl/dqv_checker.sv @@
// Port-level checker for the DNS query validator, bound to the top level.
`default_nettype none
`include "dns_query_validator_assert.svh"
module dqv_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire dqv_pkg::in_item_t in_data,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire dqv_pkg::result_t  out_data,
  input wire logic              cfg_valid,
  input wire logic              cfg_ready,
  input wire logic [7:0]        cfg_data
);

  `DQV_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))
  `DQV_ASSERT_NEXT(a_last_gives_verdict, clk, rst, in_valid && in_ready && in_data.last_byte, out_valid)
  `DQV_ASSERT_NOW(a_ok_fields, clk, rst, out_valid && out_data.ok, out_data.error_code == dqv_pkg::ERR_NONE && out_data.question_length == 9'(out_data.name_length + dqv_pkg::TYPE_CLASS_BYTES))
  `DQV_ASSERT_NOW(a_reject_fields, clk, rst, out_valid && !out_data.ok, out_data.error_code != dqv_pkg::ERR_NONE && out_data.query_id == 16'd0 && out_data.name_length == 9'd0)
  `DQV_ASSERT_NOW(a_reset_clears, clk, rst, $past(rst), !out_valid && cfg_ready)

endmodule

bind dns_query_validator dqv_checker u_dqv_checker (.*);
`default_nettype wire
